>>> rtl/core/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and constants for the sorted minimum priority queue: the
// input and result beats, one stored entry, and the links between cells.
// ----------------------------------------------------------------------------
package mpq_pkg;

  // Default number of entries the queue holds.
  localparam int CAPACITY_DEF = 16;

  // Operation codes carried in the kind field.
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // One input beat.
  typedef struct packed {
    logic               kind;
    logic signed [31:0] value;
    logic signed [31:0] priority_req;
  } in_t;

  // One result beat.
  typedef struct packed {
    logic signed [31:0] head_value;
    logic               empty_res;
    logic               dropped;
  } out_t;

  // One stored queue entry.
  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] prio;
  } entry_t;

  // Operation broadcast to every cell in the same cycle.
  typedef struct packed {
    logic   push;   // push that fits, so it is really inserted
    logic   pop;    // pop of the head entry
    entry_t item;   // entry carried by a push
  } cmd_t;

  // What a cell tells its right-hand neighbor.
  typedef struct packed {
    logic   valid;
    logic   shift;  // this cell moves its entry one place to the right
    entry_t entry;
  } left_lnk_t;

  // What a cell tells its left-hand neighbor.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } right_lnk_t;

endpackage

>>> rtl/core/mpq_cell.sv
// ----------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted queue. It compares the broadcast push key with its
// own key, and on each operation keeps its entry or takes its left neighbor's
// entry, the new entry, or its right neighbor's entry.
// ----------------------------------------------------------------------------
module mpq_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   strict_cmp,   // head slot: insert only before a larger key
  input  mpq_pkg::cmd_t          cmd,
  input  mpq_pkg::left_lnk_t     left_in,
  input  mpq_pkg::right_lnk_t    right_in,
  output mpq_pkg::left_lnk_t     left_out,
  output mpq_pkg::right_lnk_t    right_out
);
  import mpq_pkg::*;

  logic   valid_r, valid_nxt;
  entry_t entry_r, entry_nxt;
  logic   goes_after;
  logic   take_new;
  logic   take_left;

  // The new entry belongs in front of this slot's entry. The head keeps its
  // place on an equal key; every other slot yields on an equal key.
  always_comb begin
    if (strict_cmp) begin
      goes_after = cmd.item.prio < entry_r.prio;
    end else begin
      goes_after = !(entry_r.prio < cmd.item.prio);
    end
  end

  // The new entry lands in the first slot that yields or is empty.
  assign take_new  = cmd.push && (goes_after || !valid_r) && left_in.valid && !left_in.shift;
  assign take_left = cmd.push && left_in.shift;

  // Next contents of the slot.
  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    if (cmd.pop) begin
      valid_nxt = right_in.valid;
      entry_nxt = right_in.entry;
    end else if (take_left) begin
      valid_nxt = 1'b1;
      entry_nxt = left_in.entry;
    end else if (take_new) begin
      valid_nxt = 1'b1;
      entry_nxt = cmd.item;
    end
  end

  // Valid bit is reset; the entry payload is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    entry_r <= entry_nxt;
  end

  // Links to the neighbors.
  assign left_out.valid  = valid_r;
  assign left_out.shift  = cmd.push && valid_r && goes_after;
  assign left_out.entry  = entry_r;
  assign right_out.valid = valid_r;
  assign right_out.entry = entry_r;

endmodule

>>> rtl/core/min_priority_queue.sv
// ----------------------------------------------------------------------------
// min_priority_queue
// Bounded queue of (value, priority) entries kept sorted by ascending
// priority in a row of cells, the smallest priority at the head.
// ----------------------------------------------------------------------------
// The queue takes one push or pop per clock cycle: busy is always low, and
// each beat's result appears on out_item with out_strobe in the cycle after
// the beat is accepted. Every cell compares the pushed key with its own
// key in the same cycle and then moves its entry one place, however full the
// queue is. The result is shown for one cycle only; the receiver must take
// it then. A push into a full queue leaves the contents unchanged and reports
// dropped; a pop of an empty queue does nothing. head_value reads 0 while
// the queue is empty.
// ----------------------------------------------------------------------------
module min_priority_queue #(
  parameter int CAPACITY = mpq_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  mpq_pkg::in_t  in_item,
  output logic          out_strobe,
  output mpq_pkg::out_t out_item
);
  import mpq_pkg::*;

  cmd_t          cmd;
  logic          accept;
  logic          full;
  logic          out_strobe_r;
  logic          dropped_r, dropped_nxt;
  left_lnk_t     lnk_l [CAPACITY];   // output of cell i toward cell i+1
  right_lnk_t    lnk_r [CAPACITY];   // output of cell i toward cell i-1
  left_lnk_t     head_left;
  right_lnk_t    tail_right;
  logic [CAPACITY-1:0] valid_vec;

  // The queue never stalls the sender.
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = lnk_l[CAPACITY-1].valid;

  // Broadcast the operation to every cell.
  assign cmd.push      = accept && (in_item.kind == KIND_PUSH) && !full;
  assign cmd.pop       = accept && (in_item.kind == KIND_POP);
  assign cmd.item.value = in_item.value;
  assign cmd.item.prio  = in_item.priority_req;
  assign dropped_nxt   = accept && (in_item.kind == KIND_PUSH) && full;

  // Boundary links: nothing shifts into the head, nothing valid behind the tail.
  assign head_left.valid  = 1'b1;
  assign head_left.shift  = 1'b0;
  assign head_left.entry  = cmd.item;
  assign tail_right.valid = 1'b0;
  assign tail_right.entry = lnk_r[CAPACITY-1].entry;

  // Row of cells.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    left_lnk_t  from_left;
    right_lnk_t from_right;

    if (i == 0) begin : g_first
      assign from_left = head_left;
    end else begin : g_mid
      assign from_left = lnk_l[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign from_right = tail_right;
    end else begin : g_inner
      assign from_right = lnk_r[i+1];
    end

    mpq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .strict_cmp (i == 0),
      .cmd        (cmd),
      .left_in    (from_left),
      .right_in   (from_right),
      .left_out   (lnk_l[i]),
      .right_out  (lnk_r[i])
    );

    assign valid_vec[i] = lnk_l[i].valid;
  end

  // Result strobe and drop flag for the beat accepted last cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
      dropped_r    <= 1'b0;
    end else begin
      out_strobe_r <= accept;
      dropped_r    <= dropped_nxt;
    end
  end

  // The head cell already holds the post-step state during the strobe cycle.
  assign out_strobe          = out_strobe_r;
  assign out_item.head_value = lnk_l[0].valid ? lnk_l[0].entry.value : '0;
  assign out_item.empty_res  = !lnk_l[0].valid;
  assign out_item.dropped    = dropped_r;

  // Occupied cells always form one run starting at the head.
  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec + 1'b1) & valid_vec) == '0)
    else $error("occupied cells are not contiguous from the head");

  // A drop is reported only for a push that met a full queue.
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.dropped |-> $past(full) && $past(valid_vec) == valid_vec)
    else $error("drop reported without a full queue or with changed contents");

  // A pop of a non-empty queue removes exactly one entry.
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop && valid_vec[0] |=> $countones(valid_vec) == $countones($past(valid_vec)) - 1)
    else $error("pop did not remove exactly one entry");

  // A push that fits adds exactly one entry.
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> $countones(valid_vec) == $countones($past(valid_vec)) + 1)
    else $error("push did not add exactly one entry");

  // Stored keys stay in ascending order along the row.
  for (genvar j = 1; j < CAPACITY; j++) begin : g_order_chk
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
      lnk_l[j].valid |-> !(lnk_l[j].entry.prio < lnk_l[j-1].entry.prio))
      else $error("queue keys out of order");
  end

endmodule

>>> bench/tb_min_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_min_priority_queue
// Self-checking bench for the sorted minimum priority queue. A shadow copy of
// the queue predicts the head value, empty flag and drop flag of every
// accepted beat, and each result beat is compared against it in order.
// Directed beats cover ties and extreme keys, an overflowing push and a pop of
// an empty queue. Random beats then run with shifting push/pop bias and
// three levels of sender idling.
// ----------------------------------------------------------------------------
module tb_min_priority_queue;
  import mpq_pkg::*;

  localparam int DEPTH       = CAPACITY_DEF;
  localparam int PHASE_BEATS = 127;
  localparam int DRAIN_LIMIT = 1000;

  // Shadow copy of the queue plus the in-order list of expected result beats.
  class sorted_queue_checker;
    logic signed [31:0] vals[DEPTH];
    logic signed [31:0] prios[DEPTH];
    int   fill;
    out_t expected_heads[$];
    int   errors;
    int   checked;
    int   pushes, pops, drops, empty_pops, deepest;

    // Apply one accepted beat to the shadow queue and queue up its result.
    function void note_beat(in_t beat);
      out_t rep;
      int   slot;
      rep.dropped = 1'b0;
      if (beat.kind == KIND_PUSH) begin
        pushes++;
        if (fill >= DEPTH) begin
          rep.dropped = 1'b1;
          drops++;
        end else begin
          // A tie with the head keeps the head in front; other ties go first.
          if (fill == 0 || $signed(beat.priority_req) < $signed(prios[0])) begin
            slot = 0;
          end else begin
            slot = 1;
            while (slot < fill && $signed(prios[slot]) < $signed(beat.priority_req))
              slot++;
          end
          for (int k = fill; k > slot; k--) begin
            vals[k]  = vals[k-1];
            prios[k] = prios[k-1];
          end
          vals[slot]  = beat.value;
          prios[slot] = beat.priority_req;
          fill++;
          if (fill > deepest) deepest = fill;
        end
      end else begin
        pops++;
        if (fill == 0) begin
          empty_pops++;
        end else begin
          for (int k = 1; k < fill; k++) begin
            vals[k-1]  = vals[k];
            prios[k-1] = prios[k];
          end
          fill--;
        end
      end
      // Only entries below the fill level are ever read.
      rep.empty_res  = (fill == 0);
      rep.head_value = (fill == 0) ? 32'sd0 : vals[0];
      expected_heads.push_back(rep);
    endfunction

    // Compare one result beat with the oldest expectation.
    function void check_report(out_t got);
      out_t want;
      if (expected_heads.size() == 0) begin
        $error("result beat with no beat pending: head_value %0d", got.head_value);
        errors++;
        return;
      end
      want = expected_heads.pop_front();
      checked++;
      if (got.head_value !== want.head_value) begin
        $error("head_value mismatch: expected %0d, got %0d", want.head_value, got.head_value);
        errors++;
      end
      if (got.empty_res !== want.empty_res) begin
        $error("empty_res mismatch: expected %0b, got %0b", want.empty_res, got.empty_res);
        errors++;
      end
      if (got.dropped !== want.dropped) begin
        $error("dropped mismatch: expected %0b, got %0b", want.dropped, got.dropped);
        errors++;
      end
    endfunction
  endclass

  logic clk     = 1'b0;
  logic rst_n   = 1'b0;
  logic start   = 1'b0;
  in_t  in_item = '0;
  logic busy;
  logic out_strobe;
  out_t out_item;

  sorted_queue_checker board = new();

  min_priority_queue #(
    .CAPACITY(DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  // Clock with an 8-unit period.
  always #4 clk = ~clk;

  // Watch both channels: check the returning beat, then record the new one.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe === 1'b1) board.check_report(out_item);
      if (start === 1'b1 && busy === 1'b0) board.note_beat(in_item);
    end
  end

  function automatic in_t make_beat(logic kind, logic signed [31:0] val,
                                    logic signed [31:0] pri);
    in_t b;
    b.kind         = kind;
    b.value        = val;
    b.priority_req = pri;
    return b;
  endfunction

  // Random beat; keys are often crowded so that ties are common.
  function automatic in_t random_beat(int push_pct);
    in_t b;
    b.kind  = ($urandom_range(99) < push_pct) ? KIND_PUSH : KIND_POP;
    b.value = $urandom();
    case ($urandom_range(3))
      0:       b.priority_req = $urandom();
      1:       b.priority_req = int'($urandom_range(6)) - 3;
      2:       b.priority_req = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: b.priority_req = int'($urandom_range(3)) * 1000;
    endcase
    return b;
  endfunction

  // Offer one beat after a random number of idle cycles and hold it until taken.
  task automatic send_beat(input in_t beat, input int idle_pct);
    bit free_slot;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= beat;
    do begin
      @(negedge clk);
      free_slot = (busy === 1'b0);
      @(posedge clk);
    end while (!free_slot);
  endtask

  // Stop offering beats until every expected result has come back. The first
  // edge lets the monitor record the beat taken at the edge just passed.
  task automatic wait_drained();
    int guard;
    guard = 0;
    start <= 1'b0;
    @(posedge clk);
    while (board.expected_heads.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
  endtask

  // Random beats with the push/pop bias changing every 20 beats.
  task automatic run_random(input int count, input int idle_pct);
    int push_pct;
    push_pct = 55;
    for (int i = 0; i < count; i++) begin
      if (i % 20 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 80;
          1:       push_pct = 25;
          default: push_pct = 55;
        endcase
      end
      send_beat(random_beat(push_pct), idle_pct);
    end
  endtask

  // Directed beats: empty pop, ties, extreme keys, overflow, pop with junk fields.
  task automatic run_directed(input int idle_pct);
    send_beat(make_beat(KIND_POP, 32'sd0, 32'sd0), idle_pct);
    send_beat(make_beat(KIND_PUSH, 32'sh7FFFFFFF, 32'sd0), idle_pct);
    send_beat(make_beat(KIND_PUSH, 32'sh80000000, 32'sd0), idle_pct);
    send_beat(make_beat(KIND_PUSH, 32'sd1, 32'sd0), idle_pct);
    send_beat(make_beat(KIND_PUSH, -32'sd1, 32'sh80000000), idle_pct);
    send_beat(make_beat(KIND_PUSH, 32'sd2, 32'sh7FFFFFFF), idle_pct);
    send_beat(make_beat(KIND_PUSH, 32'sd3, -32'sd1), idle_pct);
    for (int i = 0; i < DEPTH - 6; i++)
      send_beat(make_beat(KIND_PUSH, 32'sd100 + i, int'($urandom_range(8)) - 4), idle_pct);
    send_beat(make_beat(KIND_PUSH, 32'sd4, 32'sh80000000), idle_pct);
    send_beat(make_beat(KIND_POP, -32'sd1, -32'sd1), idle_pct);
  endtask

  // Main sequence.
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    run_directed(34);
    wait_drained();
    run_random(PHASE_BEATS, 34);
    wait_drained();
    run_random(PHASE_BEATS, 78);
    wait_drained();
    run_random(PHASE_BEATS, 0);
    wait_drained();
    repeat (4) @(posedge clk);

    if (board.expected_heads.size() != 0) begin
      $error("%0d result beats never arrived", board.expected_heads.size());
      board.errors++;
    end

    $display("Ran %0d pushes (%0d refused when full) and %0d pops (%0d on an empty queue),",
             board.pushes, board.drops, board.pops, board.empty_pops);
    $display("deepest fill %0d of %0d, %0d result beats checked.",
             board.deepest, DEPTH, board.checked);
    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> min_priority_queue.f
rtl/core/mpq_pkg.sv
rtl/core/mpq_cell.sv
rtl/core/min_priority_queue.sv
bench/tb_min_priority_queue.sv
